// File: hw/rtl/lfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_pkg: shared types and constants for the line follower pid step
// widths of the sensor, gain, error, integral and speed paths, register
// indexes and the control bundle of the multiply-accumulate unit
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int SENSOR_BITS = 8;
  localparam int SUM_W       = SENSOR_BITS + 2;
  localparam int NUM_W       = SENSOR_BITS + 2;
  localparam int DIV_W       = SENSOR_BITS + 3;

  localparam int GAIN_W  = 10;
  localparam int BASE_W  = 8;
  localparam int ERR_W   = 3;
  localparam int DERR_W  = 4;
  localparam int INT_W   = 16;
  localparam int SPEED_W = 16;

  localparam int OPA_W  = GAIN_W + 1;
  localparam int OPB_W  = INT_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_P_RESET     = 10'd100;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET     = 10'd40;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET     = 10'd4;
  localparam logic [BASE_W-1:0] BASE_SPEED_RESET = 8'd200;

  localparam int IN_TDATA_W  = ((3 * SENSOR_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * SPEED_W + 1 + ERR_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

  // saturate a wide signed value to the 16-bit signed range
  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [ACC_W:0] v);
    logic signed [ACC_W:0] hi;
    logic signed [ACC_W:0] lo;
    hi = (ACC_W+1)'(32767);
    lo = -(ACC_W+1)'(32768);
    if (v > hi) begin
      sat16 = 16'sh7fff;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[SPEED_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/lfp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_mac: shared multiply-accumulate unit
// one signed product per enabled cycle into a product register, which is added to
// the accumulator on the following enabled cycle
// ----------------------------------------------------------------------------
module lfp_mac (
  input  logic                                clk,
  input  lfp_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [lfp_pkg::OPA_W-1:0]    op_a,
  input  logic signed [lfp_pkg::OPB_W-1:0]    op_b,
  output logic signed [lfp_pkg::ACC_W-1:0]    acc
);

  logic signed [lfp_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      prod <= '0;
      acc  <= '0;
    end else if (ctrl.en) begin
      prod <= op_a * op_b;
      acc  <= acc + prod;
    end
  end

endmodule

// File: hw/rtl/line_follow_pid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_step: pid wheel speed step for a three sensor line follower
// takes three sensor levels, forms the position error and drives the wheels
// ----------------------------------------------------------------------------
// A new request is taken only while the sequencer is idle. The result is
// loaded into the output register as the sequencer leaves its done state,
// and s_tready rises at that same edge, so the next request can be taken in
// the cycle after the load. The sequencer runs a two-step
// restoring divide for the position error and one integral update. It then
// runs three products (proportional, integral, derivative) through a single
// multiply-accumulate unit, a drain state, and a load state.
// A finished result waits in the output register while the next request is
// processed; the sequencer holds only if that register is still occupied.
// ----------------------------------------------------------------------------
module line_follow_pid_step (
  input  logic                                 clk,
  input  logic                                 rst,
  // left_level, middle_level, right_level
  input  logic [lfp_pkg::IN_TDATA_W-1:0]       s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // left_speed, right_speed, node_seen, position_error, zero pad
  output logic [lfp_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_wen,
  input  logic [lfp_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [lfp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int SB = lfp_pkg::SENSOR_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2  = 4'd2;
  localparam logic [3:0] S_INTEG = 4'd3;
  localparam logic [3:0] S_MULP  = 4'd4;
  localparam logic [3:0] S_MULI  = 4'd5;
  localparam logic [3:0] S_MULD  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [lfp_pkg::GAIN_W-1:0] gain_p;
  logic [lfp_pkg::GAIN_W-1:0] gain_i;
  logic [lfp_pkg::GAIN_W-1:0] gain_d;
  logic [lfp_pkg::BASE_W-1:0] base_speed;

  logic signed [lfp_pkg::ERR_W-1:0] last_error;
  logic signed [lfp_pkg::INT_W-1:0] integral;

  logic [lfp_pkg::DIV_W-1:0]        rem;
  logic [lfp_pkg::DIV_W-1:0]        divisor;
  logic                             neg;
  logic                             quo;
  logic                             node;
  logic signed [lfp_pkg::ERR_W-1:0] err;

  logic [SB-1:0]             lvl_l;
  logic [SB-1:0]             lvl_m;
  logic [SB-1:0]             lvl_r;
  logic [lfp_pkg::SUM_W-1:0] in_sum;
  logic [SB-1:0]             in_diff;
  logic [lfp_pkg::NUM_W-1:0] in_num;
  logic                      in_full;

  logic                             take;
  logic                             out_free;
  logic [lfp_pkg::DIV_W-1:0]        divisor2;
  logic                             ge2;
  logic                             ge1;
  logic [lfp_pkg::DIV_W-1:0]        rem_after1;
  logic [1:0]                       quo_fin;
  logic signed [lfp_pkg::ERR_W-1:0] err_new;
  logic signed [lfp_pkg::INT_W:0]   int_sum;
  logic signed [lfp_pkg::ACC_W:0]   int_wide;
  logic signed [lfp_pkg::DERR_W-1:0] derr;

  lfp_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [lfp_pkg::OPA_W-1:0]  op_a;
  logic signed [lfp_pkg::OPB_W-1:0]  op_b;
  logic signed [lfp_pkg::ACC_W-1:0]  acc;
  logic signed [lfp_pkg::ACC_W:0]    base_wide;
  logic signed [lfp_pkg::SPEED_W-1:0] left_speed;
  logic signed [lfp_pkg::SPEED_W-1:0] right_speed;

  logic signed [lfp_pkg::SPEED_W-1:0] out_left;
  logic signed [lfp_pkg::SPEED_W-1:0] out_right;
  logic                               out_node;
  logic signed [lfp_pkg::ERR_W-1:0]   out_err;

  assign s_tready = (state == S_IDLE);
  assign take     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // request unpacking and error numerator
  assign lvl_l   = s_tdata[SB-1:0];
  assign lvl_m   = s_tdata[2*SB-1:SB];
  assign lvl_r   = s_tdata[3*SB-1:2*SB];
  assign in_sum  = lfp_pkg::SUM_W'(lvl_l) + lfp_pkg::SUM_W'(lvl_m) + lfp_pkg::SUM_W'(lvl_r);
  assign in_diff = (lvl_r >= lvl_l) ? (lvl_r - lvl_l) : (lvl_l - lvl_r);
  assign in_num  = {in_diff, 1'b0} + lfp_pkg::NUM_W'(in_diff);
  assign in_full = (&lvl_l) && (&lvl_m) && (&lvl_r);

  // restoring divide, quotient is at most 3
  assign divisor2   = {divisor[lfp_pkg::DIV_W-2:0], 1'b0};
  assign ge2        = (rem >= divisor2);
  assign ge1        = (rem >= divisor);
  assign rem_after1 = ge2 ? (rem - divisor2) : rem;
  assign quo_fin    = {quo, ge1};
  assign err_new    = (divisor == '0) ? last_error :
                      neg ? -$signed({1'b0, quo_fin}) : $signed({1'b0, quo_fin});

  assign int_sum  = lfp_pkg::INT_W'(0) + $signed({integral[lfp_pkg::INT_W-1], integral})
                    + (lfp_pkg::INT_W+1)'(err);
  assign int_wide = (lfp_pkg::ACC_W+1)'(int_sum);
  assign derr     = lfp_pkg::DERR_W'(err) - lfp_pkg::DERR_W'(last_error);

  always_comb begin
    state_next   = state;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.en  = 1'b0;
    op_a         = '0;
    op_b         = '0;
    unique case (state)
      S_IDLE: begin
        mac_ctrl.clr = 1'b1;
        if (take) begin
          state_next = S_DIV1;
        end
      end
      S_DIV1:  state_next = S_DIV2;
      S_DIV2:  state_next = S_INTEG;
      S_INTEG: state_next = S_MULP;
      S_MULP: begin
        mac_ctrl.en = 1'b1;
        op_a        = $signed({1'b0, gain_p});
        op_b        = lfp_pkg::OPB_W'(err);
        state_next  = S_MULI;
      end
      S_MULI: begin
        mac_ctrl.en = 1'b1;
        op_a        = $signed({1'b0, gain_i});
        op_b        = lfp_pkg::OPB_W'(integral);
        state_next  = S_MULD;
      end
      S_MULD: begin
        mac_ctrl.en = 1'b1;
        op_a        = $signed({1'b0, gain_d});
        op_b        = lfp_pkg::OPB_W'(derr);
        state_next  = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.en = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  lfp_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  assign base_wide   = (lfp_pkg::ACC_W+1)'(base_speed);
  assign left_speed  = lfp_pkg::sat16(base_wide + (lfp_pkg::ACC_W+1)'(acc));
  assign right_speed = lfp_pkg::sat16(base_wide - (lfp_pkg::ACC_W+1)'(acc));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gain_p     <= lfp_pkg::GAIN_P_RESET;
      gain_i     <= lfp_pkg::GAIN_I_RESET;
      gain_d     <= lfp_pkg::GAIN_D_RESET;
      base_speed <= lfp_pkg::BASE_SPEED_RESET;
      last_error <= '0;
      integral   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        unique case (cfg_addr)
          lfp_pkg::REG_GAIN_P:     gain_p     <= cfg_wdata;
          lfp_pkg::REG_GAIN_I:     gain_i     <= cfg_wdata;
          lfp_pkg::REG_GAIN_D:     gain_d     <= cfg_wdata;
          lfp_pkg::REG_BASE_SPEED: base_speed <= cfg_wdata[lfp_pkg::BASE_W-1:0];
          default: ;
        endcase
      end
      if (state == S_INTEG) begin
        integral <= lfp_pkg::sat16(int_wide);
      end
      if (state == S_DONE && out_free) begin
        m_tvalid   <= 1'b1;
        last_error <= err;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rem     <= lfp_pkg::DIV_W'(in_num);
      divisor <= lfp_pkg::DIV_W'(in_sum);
      neg     <= (lvl_l > lvl_r);
      node    <= in_full;
    end
    if (state == S_DIV1) begin
      rem <= rem_after1;
      quo <= ge2;
    end
    if (state == S_DIV2) begin
      err <= err_new;
    end
    if (state == S_DONE && out_free) begin
      out_left  <= left_speed;
      out_right <= right_speed;
      out_node  <= node;
      out_err   <= err;
    end
  end

  assign m_tdata = {(lfp_pkg::OUT_TDATA_W - lfp_pkg::OUT_BITS)'(0),
                    out_err, out_node, out_right, out_left};

`ifndef NO_ASSERTIONS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_tvalid)
    else $error("finished result not presented");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_err != 3'sb100))
    else $error("position error out of range");

  a_node_centred: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_node) |-> (out_err == 3'sd0))
    else $error("node flagged with non-zero error");

  a_integral_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_INTEG) |=> $stable(integral))
    else $error("integral changed outside its update step");
`endif

endmodule

// File: tb/sv/tb_line_follow_pid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_pid_step: self-checking bench for the pid wheel speed step
// sensor triples are queued by the stimulus process and offered by a clocked
// driver; a clocked monitor predicts each accepted request from its own copy
// of the gains, error history and integral, and checks every result field.
// Runs directed corner cases, random traffic under several gain settings and
// idle patterns, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_step;

  localparam longint CYCLE_LIMIT = 1500000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     TAIL_CYCLES = 20;
  localparam int     FULL_LEVEL  = (1 << lfp_pkg::SENSOR_BITS) - 1;

  typedef struct packed {
    logic signed [lfp_pkg::SPEED_W-1:0] left_speed;
    logic signed [lfp_pkg::SPEED_W-1:0] right_speed;
    logic                               node_seen;
    logic signed [lfp_pkg::ERR_W-1:0]   position_error;
  } wheel_cmd_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [lfp_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [lfp_pkg::OUT_TDATA_W-1:0]  m_tdata;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic                             cfg_wen = 1'b0;
  logic [lfp_pkg::CFG_IDX_W-1:0]    cfg_addr = '0;
  logic [lfp_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  logic [lfp_pkg::IN_TDATA_W-1:0] pending_levels[$];
  wheel_cmd_t                     expected_cmds[$];

  int gain_p_q = lfp_pkg::GAIN_P_RESET;
  int gain_i_q = lfp_pkg::GAIN_I_RESET;
  int gain_d_q = lfp_pkg::GAIN_D_RESET;
  int base_q   = lfp_pkg::BASE_SPEED_RESET;
  int pred_last_err = 0;
  int pred_integral = 0;

  int     tx_idle = 0;
  int     rx_idle = 0;
  logic   req_taken = 1'b0;
  logic   hold_arm = 1'b0;
  logic   hold_done = 1'b0;
  int     hold_left = 0;
  longint cycle_cnt = 0;
  int     mismatches = 0;

  line_follow_pid_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic longint sat_s16(longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // advances the predicted error history and integral by one request
  function automatic wheel_cmd_t predict_wheel_cmd(logic [lfp_pkg::IN_TDATA_W-1:0] levels);
    int         l;
    int         m;
    int         r;
    int         sum;
    int         num;
    int         q;
    int         e;
    longint     drive;
    longint     spd;
    wheel_cmd_t c;
    l = int'(levels[lfp_pkg::SENSOR_BITS-1:0]);
    m = int'(levels[2*lfp_pkg::SENSOR_BITS-1:lfp_pkg::SENSOR_BITS]);
    r = int'(levels[3*lfp_pkg::SENSOR_BITS-1:2*lfp_pkg::SENSOR_BITS]);
    sum = l + m + r;
    if (sum != 0) begin
      num = 3 * (r - l);
      q = ((num < 0) ? -num : num) / sum;
      e = (num < 0) ? -q : q;
    end else begin
      e = pred_last_err;
    end
    pred_integral = int'(sat_s16(longint'(pred_integral) + e));
    drive = longint'(gain_p_q) * e + longint'(gain_i_q) * pred_integral
          + longint'(gain_d_q) * (e - pred_last_err);
    spd = sat_s16(longint'(base_q) + drive);
    c.left_speed = spd[lfp_pkg::SPEED_W-1:0];
    spd = sat_s16(longint'(base_q) - drive);
    c.right_speed = spd[lfp_pkg::SPEED_W-1:0];
    c.node_seen = (l == FULL_LEVEL) && (m == FULL_LEVEL) && (r == FULL_LEVEL);
    c.position_error = e[lfp_pkg::ERR_W-1:0];
    pred_last_err = e;
    return c;
  endfunction

  function automatic logic [lfp_pkg::IN_TDATA_W-1:0] lv(int l, int m, int r);
    logic [lfp_pkg::IN_TDATA_W-1:0] v;
    v = '0;
    v[lfp_pkg::SENSOR_BITS-1:0] = l[lfp_pkg::SENSOR_BITS-1:0];
    v[2*lfp_pkg::SENSOR_BITS-1:lfp_pkg::SENSOR_BITS] = m[lfp_pkg::SENSOR_BITS-1:0];
    v[3*lfp_pkg::SENSOR_BITS-1:2*lfp_pkg::SENSOR_BITS] = r[lfp_pkg::SENSOR_BITS-1:0];
    return v;
  endfunction

  function automatic logic [lfp_pkg::IN_TDATA_W-1:0] random_levels();
    int pick;
    int hot;
    int faint;
    pick = $urandom_range(0, 99);
    hot = $urandom_range(1, FULL_LEVEL);
    faint = $urandom_range(0, 3);
    if (pick < 10) begin
      return '0;
    end
    if (pick < 18) begin
      return lv(FULL_LEVEL, FULL_LEVEL, FULL_LEVEL);
    end
    if (pick < 29) begin
      return lv(faint, $urandom_range(0, 7), hot);
    end
    if (pick < 40) begin
      return lv(hot, $urandom_range(0, 7), faint);
    end
    return lv($urandom_range(0, FULL_LEVEL), $urandom_range(0, FULL_LEVEL),
              $urandom_range(0, FULL_LEVEL));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(logic [lfp_pkg::CFG_IDX_W-1:0] idx,
                           logic [lfp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      lfp_pkg::REG_GAIN_P:     gain_p_q = int'(data[lfp_pkg::GAIN_W-1:0]);
      lfp_pkg::REG_GAIN_I:     gain_i_q = int'(data[lfp_pkg::GAIN_W-1:0]);
      lfp_pkg::REG_GAIN_D:     gain_d_q = int'(data[lfp_pkg::GAIN_W-1:0]);
      lfp_pkg::REG_BASE_SPEED: base_q   = int'(data[lfp_pkg::BASE_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic write_all(int gp, int gi, int gd, int base);
    write_reg(lfp_pkg::REG_GAIN_P, gp[lfp_pkg::CFG_DATA_W-1:0]);
    write_reg(lfp_pkg::REG_GAIN_I, gi[lfp_pkg::CFG_DATA_W-1:0]);
    write_reg(lfp_pkg::REG_GAIN_D, gd[lfp_pkg::CFG_DATA_W-1:0]);
    write_reg(lfp_pkg::REG_BASE_SPEED, base[lfp_pkg::CFG_DATA_W-1:0]);
    @(posedge clk);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_levels.push_back(random_levels());
  endtask

  task automatic wait_drained();
    while (pending_levels.size() != 0 || s_tvalid || expected_cmds.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(int tx, int rx);
    tx_idle = tx;
    rx_idle = rx;
  endtask

  // request driver: hold the offered item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_levels.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
        s_tdata  <= pending_levels.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once
  always @(negedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    wheel_cmd_t want;
    wheel_cmd_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_cmds.push_back(predict_wheel_cmd(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.left_speed     = m_tdata[lfp_pkg::SPEED_W-1:0];
        got.right_speed    = m_tdata[2*lfp_pkg::SPEED_W-1:lfp_pkg::SPEED_W];
        got.node_seen      = m_tdata[2*lfp_pkg::SPEED_W];
        got.position_error = m_tdata[2*lfp_pkg::SPEED_W+lfp_pkg::ERR_W:2*lfp_pkg::SPEED_W+1];
        if (expected_cmds.size() == 0) begin
          report_mismatch("result with nothing pending", 0, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.left_speed != want.left_speed) begin
            report_mismatch("left_speed", got.left_speed, want.left_speed);
          end
          if (got.right_speed != want.right_speed) begin
            report_mismatch("right_speed", got.right_speed, want.right_speed);
          end
          if (got.node_seen != want.node_seen) begin
            report_mismatch("node_seen", got.node_seen, want.node_seen);
          end
          if (got.position_error != want.position_error) begin
            report_mismatch("position_error", got.position_error, want.position_error);
          end
          if (m_tdata[lfp_pkg::OUT_TDATA_W-1:2*lfp_pkg::SPEED_W+lfp_pkg::ERR_W+1] != '0) begin
            report_mismatch("pad bits",
                            m_tdata[lfp_pkg::OUT_TDATA_W-1:2*lfp_pkg::SPEED_W+lfp_pkg::ERR_W+1],
                            0);
          end
        end
      end
    end
    req_taken <= !rst && s_tvalid && s_tready;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[line_follow_pid_step] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners under the reset gains
    set_idle(15, 75);
    pending_levels.push_back(lv(0, 0, 0));
    pending_levels.push_back(lv(255, 255, 255));
    pending_levels.push_back(lv(255, 0, 0));
    pending_levels.push_back(lv(0, 0, 0));
    pending_levels.push_back(lv(0, 0, 255));
    pending_levels.push_back(lv(0, 0, 1));
    pending_levels.push_back(lv(1, 0, 0));
    pending_levels.push_back(lv(255, 255, 254));
    pending_levels.push_back(lv(254, 255, 255));
    pending_levels.push_back(lv(255, 255, 0));
    pending_levels.push_back(lv(0, 255, 255));
    pending_levels.push_back(lv(100, 0, 50));
    pending_levels.push_back(lv(10, 1, 0));
    pending_levels.push_back(lv(0, 1, 10));
    pending_levels.push_back(lv(0, 255, 1));
    pending_levels.push_back(lv(170, 85, 0));
    pending_levels.push_back(lv(85, 170, 255));
    pending_levels.push_back(lv(0, 255, 0));
    pending_levels.push_back(lv(0, 0, 0));
    wait_drained();

    // zero gains, base write with spare high bits
    write_all(0, 0, 0, 10'h300);
    push_random(60);
    wait_drained();

    write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    push_random(150);
    wait_drained();

    // maximum gains and base speed
    write_all(1023, 1023, 1023, 10'h3ff);
    set_idle(75, 15);
    push_random(150);
    wait_drained();

    write_all($urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
    set_idle(0, 0);
    push_random(170);
    hold_arm = 1'b1;
    wait_drained();

    while (expected_cmds.size() != 0) begin
      report_mismatch("result never arrived", 0, 0);
      void'(expected_cmds.pop_front());
    end
    if (mismatches == 0) begin
      $display("[line_follow_pid_step] OK");
    end else begin
      $display("[line_follow_pid_step] ERROR");
    end
    $finish;
  end

endmodule
